/* design/sst_pkg.sv */
`default_nettype none
package sst_pkg;

  // operation codes
  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned KEY_W   = 31;
  localparam int unsigned COUNT_W = 7;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_upd;
    logic chk_rd;
    logic set_ok;
    logic clr_ok;
    logic idx_cnt;
    logic idx_pos;
    logic up_rd;
    logic up_wr;
    logic ins;
    logic dn_rd;
    logic dn_wr;
    logic dec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       bad;
    logic       lo_lt_hi;
    logic       present;
    logic       room;
    logic       cnt_gt_pos;
    logic       pos_p1_lt_cnt;
    logic       up_more;
    logic       dn_more;
  } stat_t;

endpackage
`default_nettype wire

/* design/sst_ctrl.sv */
`default_nettype none
module sst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire sst_pkg::stat_t st,
  output sst_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_UPRD = 4'd4;
  localparam logic [3:0] S_UPWR = 4'd5;
  localparam logic [3:0] S_INS  = 4'd6;
  localparam logic [3:0] S_DNRD = 4'd7;
  localparam logic [3:0] S_DNWR = 4'd8;
  localparam logic [3:0] S_DEC  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (st.bad) begin
          cmd.clr_ok = 1'b1;
          state_nxt  = S_DONE;
        end else if (st.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_CMP;
        end else begin
          cmd.chk_rd = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_CHK: begin
        unique case (st.op)
          sst_pkg::OP_FIND: begin
            cmd.set_ok = 1'b1;
            state_nxt  = S_DONE;
          end
          sst_pkg::OP_ADD: begin
            if (!st.present && st.room) begin
              if (st.cnt_gt_pos) begin
                cmd.idx_cnt = 1'b1;
                state_nxt   = S_UPRD;
              end else begin
                state_nxt = S_INS;
              end
            end else begin
              cmd.clr_ok = 1'b1;
              state_nxt  = S_DONE;
            end
          end
          sst_pkg::OP_REMOVE: begin
            if (st.present) begin
              if (st.pos_p1_lt_cnt) begin
                cmd.idx_pos = 1'b1;
                state_nxt   = S_DNRD;
              end else begin
                state_nxt = S_DEC;
              end
            end else begin
              cmd.clr_ok = 1'b1;
              state_nxt  = S_DONE;
            end
          end
          default: begin
            cmd.clr_ok = 1'b1;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_UPRD: begin
        cmd.up_rd = 1'b1;
        state_nxt = S_UPWR;
      end
      S_UPWR: begin
        cmd.up_wr = 1'b1;
        state_nxt = st.up_more ? S_UPRD : S_INS;
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DNRD: begin
        cmd.dn_rd = 1'b1;
        state_nxt = S_DNWR;
      end
      S_DNWR: begin
        cmd.dn_wr = 1'b1;
        state_nxt = st.dn_more ? S_DNRD : S_DEC;
      end
      S_DEC: begin
        cmd.dec   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule
`default_nettype wire

/* design/sst_dpath.sv */
`default_nettype none
module sst_dpath #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sst_pkg::cmd_t                cmd,
  input  wire logic [1:0]                   op_in,
  input  wire logic [sst_pkg::ELEM_W-1:0]   elem_in,
  output sst_pkg::stat_t                    st,
  output logic                              ok,
  output logic [sst_pkg::COUNT_W-1:0]       count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = sst_pkg::KEY_W;

  logic [KW-1:0] mem [CAPACITY];

  logic [KW-1:0] key_r, rd_data_r;
  logic          neg_r, hit_r, ok_r;
  logic [1:0]    op_r;
  logic [CW-1:0] lo_r, hi_r, mid_r, idx_r, count_r;

  logic [CW-1:0] mid;
  logic [CW:0]   idx_m1, idx_p1, idx_p2, lo_p1;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [KW-1:0] wr_data;

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_m1 = {1'b0, idx_r} - (CW+1)'(1);
  assign idx_p1 = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx_r} + (CW+1)'(2);
  assign lo_p1  = {1'b0, lo_r} + (CW+1)'(1);

  // read address select
  always_comb begin
    rd_en   = cmd.srch_rd | cmd.chk_rd | cmd.up_rd | cmd.dn_rd;
    rd_addr = idx_p1[AW-1:0];
    priority if (cmd.srch_rd) begin
      rd_addr = mid[AW-1:0];
    end else if (cmd.chk_rd) begin
      rd_addr = lo_r[AW-1:0];
    end else if (cmd.up_rd) begin
      rd_addr = idx_m1[AW-1:0];
    end else begin
      rd_addr = idx_p1[AW-1:0];
    end
  end

  // write address select
  always_comb begin
    wr_en   = cmd.up_wr | cmd.dn_wr | cmd.ins;
    wr_addr = idx_r[AW-1:0];
    wr_data = rd_data_r;
    if (cmd.ins) begin
      wr_addr = lo_r[AW-1:0];
      wr_data = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_in;
      key_r <= elem_in[KW-1:0];
      neg_r <= elem_in[sst_pkg::ELEM_W-1];
      lo_r  <= '0;
      hi_r  <= count_r;
    end else if (cmd.srch_upd) begin
      if (rd_data_r < key_r) begin
        lo_r <= mid_r + CW'(1);
      end else begin
        hi_r <= mid_r;
      end
    end
    if (cmd.srch_rd) begin
      mid_r <= mid;
    end
    if (cmd.chk_rd) begin
      hit_r <= (lo_r < count_r);
    end
    if (cmd.idx_cnt) begin
      idx_r <= count_r;
    end else if (cmd.idx_pos) begin
      idx_r <= lo_r;
    end else if (cmd.up_wr) begin
      idx_r <= idx_m1[CW-1:0];
    end else if (cmd.dn_wr) begin
      idx_r <= idx_p1[CW-1:0];
    end
    if (cmd.set_ok) begin
      ok_r <= st.present;
    end else if (cmd.clr_ok) begin
      ok_r <= 1'b0;
    end else if (cmd.ins || cmd.dec) begin
      ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_comb begin
    st.op            = op_r;
    st.bad           = neg_r || (op_r == sst_pkg::OP_NONE);
    st.lo_lt_hi      = (lo_r < hi_r);
    st.present       = hit_r && (rd_data_r == key_r);
    st.room          = (count_r < CW'(CAPACITY));
    st.cnt_gt_pos    = (count_r > lo_r);
    st.pos_p1_lt_cnt = (lo_p1 < {1'b0, count_r});
    st.up_more       = (idx_m1 > {1'b0, lo_r});
    st.dn_more       = (idx_p2 < {1'b0, count_r});
  end

  assign ok    = ok_r;
  assign count = sst_pkg::COUNT_W'(count_r);

endmodule
`default_nettype wire

/* design/sorted_set_table.sv */
// find, failed add and failed remove: binary search over the filled entries, then a check
// negative element or unused code: straight to the result; a successful add or remove
//   also shifts every entry above the slot, one read and one write per entry moved
// throughput: one word at a time; the next start is taken the cycle after out_valid
// the entry store, used for one access at a time, sets the pace: one read or one write per cycle
// reset (rst_n low, synchronous) empties the set and returns to idle; store contents stay
`default_nettype none
module sorted_set_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // command side
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [sst_pkg::ELEM_W-1:0] in_element,
  // result side, one word per command, cannot be held off
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [sst_pkg::COUNT_W-1:0]     out_count
);

  sst_pkg::cmd_t  cmd;
  sst_pkg::stat_t st;
  logic           done;

  // sequencer: binary search, then shift loop one entry per read/write pair
  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // entry store, search bounds, shift index and fill count
  sst_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .op_in   (in_operation),
    .elem_in (in_element),
    .st      (st),
    .ok      (out_ok),
    .count   (out_count)
  );

  // result word is shown for the one cycle spent in the done state
  assign out_valid = done;

endmodule
`default_nettype wire

/* design/sst_check.sv */
`default_nettype none
module sst_check (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // a taken command always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command taken but block not busy");

  // a result only appears while a command is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word outside a command");

  // one word per command, then idle
  a_valid_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result not followed by idle");

  // busy only drops right after a result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid))
    else $error("busy dropped without a result");

endmodule

bind sorted_set_table sst_check u_sst_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned CAPACITY     = 64;
  // worst word, a full search and a shift across the whole store, is well under this
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_WORDS = 1550;
  // settle time after the last result, about one worst-case word
  localparam int unsigned TAIL_CYCLES  = 160;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic                        ok;
    logic [sst_pkg::COUNT_W-1:0] count;
  } set_result_t;

  // mirror of the sorted set plus the results still owed by the block
  class set_tracker;
    bit [sst_pkg::KEY_W-1:0] mirror_keys[$];
    set_result_t             owed_results[$];
    int unsigned             failures;
    int unsigned             reports;

    function new();
      failures = 0;
      reports  = 0;
    endfunction

    // first slot whose key is not below the given one
    function int unsigned first_not_below(bit [sst_pkg::KEY_W-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = mirror_keys.size();
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (mirror_keys[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_command(logic [1:0] op, logic [sst_pkg::ELEM_W-1:0] elem);
      set_result_t              res;
      int unsigned              slot;
      bit                       hit;
      bit [sst_pkg::KEY_W-1:0]  key;
      res.ok = 1'b0;
      key    = elem[sst_pkg::KEY_W-1:0];
      if (!elem[sst_pkg::ELEM_W-1] && op != sst_pkg::OP_NONE) begin
        slot = first_not_below(key);
        hit  = (slot < mirror_keys.size()) && (mirror_keys[slot] == key);
        case (op)
          sst_pkg::OP_FIND: res.ok = hit;
          sst_pkg::OP_ADD: begin
            if (!hit && mirror_keys.size() < CAPACITY) begin
              mirror_keys.insert(slot, key);
              res.ok = 1'b1;
            end
          end
          sst_pkg::OP_REMOVE: begin
            if (hit) begin
              mirror_keys.delete(slot);
              res.ok = 1'b1;
            end
          end
          default: ;
        endcase
      end
      res.count = sst_pkg::COUNT_W'(mirror_keys.size());
      owed_results.push_back(res);
    endfunction

    function void check_result(logic ok, logic [sst_pkg::COUNT_W-1:0] count);
      set_result_t want;
      if (owed_results.size() == 0) begin
        failures++;
        reports++;
        if (reports <= MAX_REPORTS)
          $display("unexpected result word: ok=%0d count=%0d", ok, count);
        return;
      end
      want = owed_results.pop_front();
      if (ok !== want.ok || count !== want.count) begin
        failures++;
        reports++;
        if (reports <= MAX_REPORTS)
          $display("mismatch: expected ok=%0d count=%0d, got ok=%0d count=%0d",
                   want.ok, want.count, ok, count);
      end
    endfunction

    function int unsigned owed();
      return owed_results.size();
    endfunction

    // a value currently in the set, or a small one when empty
    function logic [sst_pkg::ELEM_W-1:0] held_value();
      if (mirror_keys.size() == 0) return sst_pkg::ELEM_W'($urandom_range(0, 127));
      return {1'b0, mirror_keys[$urandom_range(0, mirror_keys.size() - 1)]};
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [1:0]                  in_operation;
  logic [sst_pkg::ELEM_W-1:0]  in_element;
  logic                        out_valid;
  logic                        out_ok;
  logic [sst_pkg::COUNT_W-1:0] out_count;

  set_tracker  sb;
  int unsigned burst_left;
  int unsigned random_sent;

  sorted_set_table #(.CAPACITY(CAPACITY)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_element   (in_element),
    .out_valid    (out_valid),
    .out_ok       (out_ok),
    .out_count    (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: every strobe is one word, checked at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_ok, out_count);
  end

  // watchdog: cycles with neither a command taken nor a result seen
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("watchdog expired with %0d results outstanding", sb.owed());
    $display("RESULT: ERROR");
    $finish;
  end

  // one command word; bursts of random length with random gaps in between
  task automatic send_word(logic [1:0] op, logic [sst_pkg::ELEM_W-1:0] elem);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_element   <= elem;
    // taken at the first rising edge with busy low
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(op, elem);
  endtask

  // hold commands off until the block has answered everything
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (sb.owed() != 0) @(posedge clk);
  endtask

  function automatic logic [sst_pkg::ELEM_W-1:0] extreme_value();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h7fff_fffe;
      4: return 32'h8000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // non-negative with every key bit random
  function automatic logic [sst_pkg::ELEM_W-1:0] wide_value();
    logic [sst_pkg::ELEM_W-1:0] v;
    v = $urandom();
    return {1'b0, v[sst_pkg::KEY_W-1:0]};
  endfunction

  function automatic logic [sst_pkg::ELEM_W-1:0] mixed_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return sst_pkg::ELEM_W'($urandom_range(0, 95));
    if (r < 75) return sb.held_value();
    if (r < 88) return wide_value();
    if (r < 95) return $urandom();
    return extreme_value();
  endfunction

  function automatic logic [1:0] mixed_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return sst_pkg::OP_ADD;
    if (r < 70) return sst_pkg::OP_REMOVE;
    if (r < 95) return sst_pkg::OP_FIND;
    return sst_pkg::OP_NONE;
  endfunction

  initial begin
    int unsigned kind;
    int unsigned len;
    sb           = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = sst_pkg::OP_FIND;
    in_element   = '0;
    burst_left   = 0;
    random_sent  = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty set, extremes, negatives, duplicates, unused code
    send_word(sst_pkg::OP_FIND,   32'h0000_0000);   // find on empty set
    send_word(sst_pkg::OP_REMOVE, 32'h0000_0005);   // remove of absent element
    send_word(sst_pkg::OP_ADD,    32'h0000_0000);
    send_word(sst_pkg::OP_ADD,    32'h0000_0000);   // duplicate add
    send_word(sst_pkg::OP_ADD,    32'h7fff_ffff);   // largest element
    send_word(sst_pkg::OP_FIND,   32'h7fff_ffff);
    send_word(sst_pkg::OP_ADD,    32'h8000_0000);   // negative add, most negative
    send_word(sst_pkg::OP_ADD,    32'hffff_ffff);   // negative add, minus one
    send_word(sst_pkg::OP_FIND,   32'hffff_ffff);   // negative find
    send_word(sst_pkg::OP_REMOVE, 32'h8000_0000);   // negative remove
    send_word(sst_pkg::OP_NONE,   32'h0000_0007);   // unused code
    send_word(sst_pkg::OP_NONE,   32'hffff_ffff);
    send_word(sst_pkg::OP_ADD,    32'h0000_0064);
    send_word(sst_pkg::OP_ADD,    32'h0000_0032);   // insert below, shifts up
    send_word(sst_pkg::OP_ADD,    32'h0000_004b);   // insert in the middle
    send_word(sst_pkg::OP_FIND,   32'h0000_0032);
    send_word(sst_pkg::OP_FIND,   32'h0000_003c);   // absent, between entries
    send_word(sst_pkg::OP_REMOVE, 32'h0000_0064);
    send_word(sst_pkg::OP_REMOVE, 32'h0000_0064);   // already gone
    send_word(sst_pkg::OP_REMOVE, 32'h0000_0000);   // lowest entry, shifts down
    send_word(sst_pkg::OP_FIND,   32'h0000_0000);
    send_word(sst_pkg::OP_REMOVE, 32'h7fff_ffff);
    send_word(sst_pkg::OP_ADD,    32'h0000_0001);
    send_word(sst_pkg::OP_FIND,   32'h7fff_fffe);
    wait_for_results();

    // random part, built from short sequences of different flavors
    while (random_sent < RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // mixed traffic on a small value pool so hits are common
        len = $urandom_range(10, 40);
        repeat (len) send_word(mixed_op(), mixed_value());
        random_sent += len;
      end else if (kind <= 5) begin
        // fill the store to capacity, then push against the full case
        while (sb.mirror_keys.size() < CAPACITY) begin
          send_word(sst_pkg::OP_ADD,
                    ($urandom_range(0, 1) != 0) ? sst_pkg::ELEM_W'($urandom_range(0, 255))
                                                : wide_value());
          random_sent++;
        end
        len = $urandom_range(2, 6);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: send_word(sst_pkg::OP_ADD, wide_value());
            1: send_word(sst_pkg::OP_ADD, sb.held_value());
            2: send_word(sst_pkg::OP_FIND, sb.held_value());
            default: send_word(sst_pkg::OP_FIND, wide_value());
          endcase
        end
        random_sent += len;
      end else if (kind == 6) begin
        // drain: mostly removes of present elements
        len = $urandom_range(20, 70);
        repeat (len) begin
          if ($urandom_range(0, 99) < 85) send_word(sst_pkg::OP_REMOVE, sb.held_value());
          else send_word(sst_pkg::OP_REMOVE, mixed_value());
        end
        random_sent += len;
      end else if (kind == 7) begin
        // noise: any code, any element
        len = $urandom_range(5, 15);
        repeat (len) send_word(2'($urandom_range(0, 3)), $urandom());
        random_sent += len;
      end else begin
        // lookups against wide entries
        len = $urandom_range(10, 30);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: send_word(sst_pkg::OP_ADD, wide_value());
            1: send_word(sst_pkg::OP_FIND, wide_value());
            default: send_word(sst_pkg::OP_FIND, sb.held_value());
          endcase
        end
        random_sent += len;
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    // drain, then let the block sit for about one worst-case word
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.owed() != 0) begin
      sb.failures++;
      $display("%0d results never arrived", sb.owed());
    end
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/sst_pkg.sv
design/sst_ctrl.sv
design/sst_dpath.sv
design/sorted_set_table.sv
design/sst_check.sv
tb/sv/testbench.sv
